[src/bspt_pkg.sv]
package bspt_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION_LIMIT = 2'd2;

    // Register widths and reset values
    localparam int CFG_LEN_W = 7;
    localparam int THR_W     = 16;
    localparam int LIMIT_W   = 10;

    localparam logic [CFG_LEN_W-1:0] LEN_RESET   = 7'd20;
    localparam logic [THR_W-1:0]     THR_RESET   = 16'd512;
    localparam logic [LIMIT_W-1:0]   LIMIT_RESET = 10'd5;

    // Result widths
    localparam int POS_W       = 11;
    localparam int CASH_W      = 48;
    localparam int CASH_WIDE_W = CASH_W + 2;

    localparam logic signed [CASH_W-1:0] CASH_MAX = {1'b0, {(CASH_W-1){1'b1}}};
    localparam logic signed [CASH_W-1:0] CASH_MIN = {1'b1, {(CASH_W-1){1'b0}}};

    // Threshold squared carries 16 fraction bits
    localparam int FRAC2_SH = 16;

    // Shared multiplier: 32x32 partial products into a 128-bit accumulator
    localparam int LIMB_W     = 32;
    localparam int ACC_W      = 128;
    localparam int LIMBS      = ACC_W / LIMB_W;
    localparam int LIMB_IDX_W = $clog2(LIMBS);

    typedef enum logic [1:0] {
        ACT_HOLD = 2'd0,
        ACT_BUY  = 2'd1,
        ACT_SELL = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OLD,
        ST_SQOLD,
        ST_SQNEW,
        ST_NP,
        ST_MAG2,
        ST_NSQ,
        ST_SUM2,
        ST_THR2,
        ST_RTHR,
        ST_TRADE,
        ST_PNL,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_RUN,
        MS_ACC,
        MS_DONE
    } t_mul_state;

    typedef struct packed {
        logic                  start;
        logic [LIMB_IDX_W-1:0] la_m1;
        logic [LIMB_IDX_W-1:0] lb_m1;
        logic [ACC_W-1:0]      a;
        logic [ACC_W-1:0]      b;
    } t_mul_req;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] prod;
    } t_mul_rsp;

    // Clamp a widened cash value to the signed 48-bit range
    function automatic logic signed [CASH_W-1:0] sat_cash(
        input logic signed [CASH_WIDE_W-1:0] v
    );
        logic signed [CASH_WIDE_W-1:0] hi;
        logic signed [CASH_WIDE_W-1:0] lo;
        hi = {2'b00, CASH_MAX};
        lo = {2'b11, CASH_MIN};
        if (v > hi) begin
            return CASH_MAX;
        end else if (v < lo) begin
            return CASH_MIN;
        end else begin
            return v[CASH_W-1:0];
        end
    endfunction

endpackage

[src/bollinger_signal_position_tracker.sv]
// Bollinger band signal generator with position and cash tracking.
// Input channel (i_in_valid / o_in_ready) takes one closing price per item;
// output channel (o_out_valid / i_out_ready) returns one result per item:
// window-full flag, action (hold/buy/sell), position, cash and marked PnL.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes
// window length, band threshold and position limit; writing the window
// length empties the window but keeps position and cash.
// All products go through one shared 32x32 multiplier that walks limb
// pairs, forming and then accumulating one partial product per pair.
// An item with a full window runs the band test before its trade step;
// while the window fills an item skips straight to the marked PnL.
// o_in_ready is high only while no item is being worked on.
// A finished result sits in an output register; the next item is taken
// while it waits. If the receiver stalls with a second result ready, the
// block holds that result internally until the register frees up.
// Synchronous active-low reset restores default registers, empties the
// window and clears position and cash; no clearing pass is needed since
// the fill count guards reads of stale window entries.
module bollinger_signal_position_tracker
    import bspt_pkg::*;
#(
    parameter int MAX_WINDOW = 64,
    parameter int PRICE_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [PRICE_BITS-1:0]    i_price,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_window_full,
    output logic [1:0]               o_action,
    output logic signed [POS_W-1:0]  o_position,
    output logic signed [CASH_W-1:0] o_cashflow,
    output logic signed [CASH_W-1:0] o_marked_pnl,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = PRICE_BITS + LEN_W;
    localparam int SQ_W  = 2 * PRICE_BITS + LEN_W;
    localparam int R_W   = SQ_W + LEN_W;
    localparam int L_SUM = (SUM_W + LIMB_W - 1) / LIMB_W;
    localparam int L_SQ  = (SQ_W + LIMB_W - 1) / LIMB_W;
    localparam int L_R   = (R_W + LIMB_W - 1) / LIMB_W;
    localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;

    // Control state
    t_state                   r_state;
    t_state                   n_state;
    logic [CFG_LEN_W-1:0]     r_len;
    logic [CFG_LEN_W-1:0]     n_len;
    logic [THR_W-1:0]         r_thr;
    logic [THR_W-1:0]         n_thr;
    logic [LIMIT_W-1:0]       r_limit;
    logic [LIMIT_W-1:0]       n_limit;
    logic [IDX_W-1:0]         r_slot;
    logic [IDX_W-1:0]         n_slot;
    logic [LEN_W-1:0]         r_fill;
    logic [LEN_W-1:0]         n_fill;
    logic [SUM_W-1:0]         r_sum;
    logic [SUM_W-1:0]         n_sum;
    logic [SQ_W-1:0]          r_sq;
    logic [SQ_W-1:0]          n_sq;
    logic signed [POS_W-1:0]  r_held;
    logic signed [POS_W-1:0]  n_held;
    logic signed [CASH_W-1:0] r_cash;
    logic signed [CASH_W-1:0] n_cash;
    logic                     r_out_valid;

    // Per-item working registers
    logic [PRICE_BITS-1:0]    r_price;
    logic [PRICE_BITS-1:0]    n_price;
    logic                     r_was_full;
    logic                     n_was_full;
    t_action                  r_action;
    t_action                  n_action;
    logic [SUM_W-1:0]         r_mag;
    logic [SUM_W-1:0]         n_mag;
    logic                     r_d_neg;
    logic                     n_d_neg;
    logic                     r_d_pos;
    logic                     n_d_pos;
    logic [ACC_W-1:0]         r_lhs;
    logic [ACC_W-1:0]         n_lhs;
    logic [R_W-1:0]           r_rv;
    logic [R_W-1:0]           n_rv;
    logic [2*THR_W-1:0]       r_thr2;
    logic [2*THR_W-1:0]       n_thr2;
    logic                     r_outside;
    logic                     n_outside;
    logic signed [CASH_W-1:0] r_pnl;
    logic signed [CASH_W-1:0] n_pnl;

    // Output register
    logic                     r_o_full;
    t_action                  r_o_action;
    logic signed [POS_W-1:0]  r_o_pos;
    logic signed [CASH_W-1:0] r_o_cash;
    logic signed [CASH_W-1:0] r_o_pnl;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    logic                      w_in_acc;
    logic                      w_out_load;
    logic                      w_wr_en;
    logic [PRICE_BITS-1:0]     w_old;
    logic [CMP_W-1:0]          w_len_ext;
    logic [LEN_W-1:0]          w_n;
    logic                      w_full;
    logic [LEN_W-1:0]          w_slot_inc;
    logic                      w_done;
    logic [ACC_W-1:0]          w_prod;
    logic [SUM_W-1:0]          w_np;
    logic [SUM_W-1:0]          w_old_sub;
    logic [POS_W-1:0]          w_held_mag;
    logic signed [POS_W:0]     w_held_ext;
    logic signed [POS_W:0]     w_lim_ext;
    logic                      w_buy_room;
    logic                      w_sell_room;
    logic signed [CASH_WIDE_W-1:0] w_cash_ext;
    logic signed [CASH_WIDE_W-1:0] w_price_ext;
    logic signed [CASH_WIDE_W-1:0] w_term;

    assign w_done = mul_rsp.done;
    assign w_prod = mul_rsp.prod;

    // Effective window length: zero acts as one, clamp to the store depth
    assign w_len_ext = CMP_W'(r_len);
    always_comb begin
        if (w_len_ext == '0) begin
            w_n = LEN_W'(1);
        end else if (w_len_ext > CMP_W'(MAX_WINDOW)) begin
            w_n = LEN_W'(MAX_WINDOW);
        end else begin
            w_n = LEN_W'(w_len_ext);
        end
    end

    assign w_full     = (r_fill >= w_n);
    assign w_slot_inc = LEN_W'(r_slot) + LEN_W'(1);
    assign w_np       = w_prod[SUM_W-1:0];
    assign w_old_sub  = r_was_full ? SUM_W'(w_old) : '0;
    assign w_held_mag = r_held[POS_W-1] ? POS_W'(-r_held) : POS_W'(r_held);
    assign w_held_ext = {r_held[POS_W-1], r_held};
    assign w_lim_ext  = {2'b00, r_limit};
    assign w_buy_room = (w_held_ext < w_lim_ext);
    assign w_sell_room = (w_held_ext > -w_lim_ext);
    assign w_cash_ext  = {{2{r_cash[CASH_W-1]}}, r_cash};
    assign w_price_ext = {{(CASH_WIDE_W-PRICE_BITS){1'b0}}, r_price};
    assign w_term = r_held[POS_W-1] ? -$signed({2'b00, w_prod[CASH_W-1:0]})
                                    :  $signed({2'b00, w_prod[CASH_W-1:0]});

    bspt_window #(
        .DEPTH  (MAX_WINDOW),
        .DATA_W (PRICE_BITS)
    ) u_window (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_price),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (r_slot),
        .o_rd_data (w_old)
    );

    bspt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_OLD;
                end
            end
            ST_OLD: n_state = r_was_full ? ST_SQOLD : ST_SQNEW;
            ST_SQOLD: begin
                if (w_done) begin
                    n_state = ST_SQNEW;
                end
            end
            ST_SQNEW: begin
                if (w_done) begin
                    n_state = w_full ? ST_NP : ST_PNL;
                end
            end
            ST_NP: begin
                if (w_done) begin
                    n_state = ST_MAG2;
                end
            end
            ST_MAG2: begin
                if (w_done) begin
                    n_state = ST_NSQ;
                end
            end
            ST_NSQ: begin
                if (w_done) begin
                    n_state = ST_SUM2;
                end
            end
            ST_SUM2: begin
                if (w_done) begin
                    n_state = ST_THR2;
                end
            end
            ST_THR2: begin
                if (w_done) begin
                    n_state = ST_RTHR;
                end
            end
            ST_RTHR: begin
                if (w_done) begin
                    n_state = ST_TRADE;
                end
            end
            ST_TRADE: n_state = ST_PNL;
            ST_PNL: begin
                if (w_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: handshakes, store write, multiplier operands
    always_comb begin
        o_in_ready    = (r_state == ST_IDLE);
        w_in_acc      = (r_state == ST_IDLE) && i_in_valid;
        w_wr_en       = (r_state == ST_OLD);
        w_out_load    = (r_state == ST_OUT) && (!r_out_valid || i_out_ready);
        mul_req.start = 1'b0;
        mul_req.la_m1 = '0;
        mul_req.lb_m1 = '0;
        mul_req.a     = '0;
        mul_req.b     = '0;
        case (r_state)
            ST_SQOLD: begin
                mul_req.start = 1'b1;
                mul_req.a     = ACC_W'(w_old);
                mul_req.b     = ACC_W'(w_old);
            end
            ST_SQNEW: begin
                mul_req.start = 1'b1;
                mul_req.a     = ACC_W'(r_price);
                mul_req.b     = ACC_W'(r_price);
            end
            ST_NP: begin
                mul_req.start = 1'b1;
                mul_req.a     = ACC_W'(w_n);
                mul_req.b     = ACC_W'(r_price);
            end
            ST_MAG2: begin
                mul_req.start = 1'b1;
                mul_req.la_m1 = LIMB_IDX_W'(L_SUM - 1);
                mul_req.lb_m1 = LIMB_IDX_W'(L_SUM - 1);
                mul_req.a     = ACC_W'(r_mag);
                mul_req.b     = ACC_W'(r_mag);
            end
            ST_NSQ: begin
                mul_req.start = 1'b1;
                mul_req.la_m1 = LIMB_IDX_W'(L_SQ - 1);
                mul_req.a     = ACC_W'(r_sq);
                mul_req.b     = ACC_W'(w_n);
            end
            ST_SUM2: begin
                mul_req.start = 1'b1;
                mul_req.la_m1 = LIMB_IDX_W'(L_SUM - 1);
                mul_req.lb_m1 = LIMB_IDX_W'(L_SUM - 1);
                mul_req.a     = ACC_W'(r_sum);
                mul_req.b     = ACC_W'(r_sum);
            end
            ST_THR2: begin
                mul_req.start = 1'b1;
                mul_req.a     = ACC_W'(r_thr);
                mul_req.b     = ACC_W'(r_thr);
            end
            ST_RTHR: begin
                mul_req.start = 1'b1;
                mul_req.la_m1 = LIMB_IDX_W'(L_R - 1);
                mul_req.a     = ACC_W'(r_rv);
                mul_req.b     = ACC_W'(r_thr2);
            end
            ST_PNL: begin
                mul_req.start = 1'b1;
                mul_req.a     = ACC_W'(w_held_mag);
                mul_req.b     = ACC_W'(r_price);
            end
            default: begin
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    // Datapath next values
    always_comb begin
        n_len      = r_len;
        n_thr      = r_thr;
        n_limit    = r_limit;
        n_slot     = r_slot;
        n_fill     = r_fill;
        n_sum      = r_sum;
        n_sq       = r_sq;
        n_held     = r_held;
        n_cash     = r_cash;
        n_price    = r_price;
        n_was_full = r_was_full;
        n_action   = r_action;
        n_mag      = r_mag;
        n_d_neg    = r_d_neg;
        n_d_pos    = r_d_pos;
        n_lhs      = r_lhs;
        n_rv       = r_rv;
        n_thr2     = r_thr2;
        n_outside  = r_outside;
        n_pnl      = r_pnl;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_price    = i_price;
                    n_was_full = w_full;
                    n_action   = ACT_HOLD;
                end
            end
            ST_OLD: begin
                // drop the oldest price once the window is full, add the new one
                n_sum  = r_sum - w_old_sub + SUM_W'(r_price);
                n_slot = (w_slot_inc == w_n) ? '0 : IDX_W'(w_slot_inc);
                if (!w_full) begin
                    n_fill = r_fill + LEN_W'(1);
                end
            end
            ST_SQOLD: begin
                if (w_done) begin
                    n_sq = r_sq - w_prod[SQ_W-1:0];
                end
            end
            ST_SQNEW: begin
                if (w_done) begin
                    n_sq = r_sq + w_prod[SQ_W-1:0];
                end
            end
            ST_NP: begin
                // d = N*price - sum, kept as sign flags and magnitude
                if (w_done) begin
                    n_d_neg = (w_np < r_sum);
                    n_d_pos = (w_np > r_sum);
                    n_mag   = (w_np >= r_sum) ? (w_np - r_sum) : (r_sum - w_np);
                end
            end
            ST_MAG2: begin
                if (w_done) begin
                    n_lhs = w_prod;
                end
            end
            ST_NSQ: begin
                if (w_done) begin
                    n_rv = w_prod[R_W-1:0];
                end
            end
            ST_SUM2: begin
                if (w_done) begin
                    n_rv = r_rv - w_prod[R_W-1:0];
                end
            end
            ST_THR2: begin
                if (w_done) begin
                    n_thr2 = w_prod[2*THR_W-1:0];
                end
            end
            ST_RTHR: begin
                // d^2 * 2^16 against thr^2 * r
                if (w_done) begin
                    n_outside = ({r_lhs[ACC_W-FRAC2_SH-1:0], {FRAC2_SH{1'b0}}} >= w_prod);
                end
            end
            ST_TRADE: begin
                if (!r_d_neg && r_outside && w_buy_room) begin
                    n_action = ACT_BUY;
                    n_held   = r_held + POS_W'(1);
                    n_cash   = sat_cash(w_cash_ext - w_price_ext);
                end else if (!r_d_pos && r_outside && w_sell_room) begin
                    n_action = ACT_SELL;
                    n_held   = r_held - POS_W'(1);
                    n_cash   = sat_cash(w_cash_ext + w_price_ext);
                end
            end
            ST_PNL: begin
                if (w_done) begin
                    n_pnl = sat_cash(w_cash_ext + w_term);
                end
            end
            default: begin
            end
        endcase

        // Configuration writes
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WINDOW_LENGTH: begin
                    n_len  = i_cfg_data[CFG_LEN_W-1:0];
                    n_slot = '0;
                    n_fill = '0;
                    n_sum  = '0;
                    n_sq   = '0;
                end
                CFG_BAND_THRESHOLD: n_thr   = i_cfg_data[THR_W-1:0];
                CFG_POSITION_LIMIT: n_limit = i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= LEN_RESET;
            r_thr       <= THR_RESET;
            r_limit     <= LIMIT_RESET;
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_held      <= '0;
            r_cash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_thr   <= n_thr;
            r_limit <= n_limit;
            r_slot  <= n_slot;
            r_fill  <= n_fill;
            r_sum   <= n_sum;
            r_sq    <= n_sq;
            r_held  <= n_held;
            r_cash  <= n_cash;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_price    <= n_price;
        r_was_full <= n_was_full;
        r_action   <= n_action;
        r_mag      <= n_mag;
        r_d_neg    <= n_d_neg;
        r_d_pos    <= n_d_pos;
        r_lhs      <= n_lhs;
        r_rv       <= n_rv;
        r_thr2     <= n_thr2;
        r_outside  <= n_outside;
        r_pnl      <= n_pnl;
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_full   <= w_full;
            r_o_action <= r_action;
            r_o_pos    <= r_held;
            r_o_cash   <= r_cash;
            r_o_pnl    <= r_pnl;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_window_full = r_o_full;
    assign o_action      = r_o_action;
    assign o_position    = r_o_pos;
    assign o_cashflow    = r_o_cash;
    assign o_marked_pnl  = r_o_pnl;

endmodule

[src/bspt_mul.sv]
module bspt_mul
    import bspt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    t_mul_state r_state;
    t_mul_state n_state;

    logic [ACC_W-1:0]      r_a;
    logic [ACC_W-1:0]      r_b;
    logic [LIMB_IDX_W-1:0] r_la;
    logic [LIMB_IDX_W-1:0] r_lb;
    logic [LIMB_IDX_W-1:0] r_i;
    logic [LIMB_IDX_W-1:0] r_j;
    logic [2*LIMB_W-1:0]   r_pp;
    logic [LIMB_IDX_W:0]   r_sh;
    logic                  r_ppv;
    logic [ACC_W-1:0]      r_acc;

    logic [2*LIMB_W-1:0] w_pp;
    logic [ACC_W-1:0]    w_pp_shift;
    logic                w_last;

    assign w_last     = (r_i == r_la) && (r_j == r_lb);
    assign w_pp       = r_a[r_i*LIMB_W +: LIMB_W] * r_b[r_j*LIMB_W +: LIMB_W];
    assign w_pp_shift = {{(ACC_W-2*LIMB_W){1'b0}}, r_pp} << (r_sh * LIMB_W);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            MS_IDLE: begin
                if (i_req.start) begin
                    n_state = MS_RUN;
                end
            end
            MS_RUN: begin
                if (w_last) begin
                    n_state = MS_ACC;
                end
            end
            MS_ACC:  n_state = MS_DONE;
            MS_DONE: n_state = MS_IDLE;
            default: n_state = MS_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_rsp.done = (r_state == MS_DONE);
        o_rsp.prod = r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MS_IDLE;
            r_ppv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ppv   <= (r_state == MS_RUN);
        end
    end

    // Latch operands, step through limb pairs, add each registered partial product in the following cycle
    always_ff @(posedge i_clk) begin
        if (r_state == MS_IDLE && i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_la  <= i_req.la_m1;
            r_lb  <= i_req.lb_m1;
            r_i   <= '0;
            r_j   <= '0;
            r_acc <= '0;
        end else begin
            if (r_state == MS_RUN) begin
                r_pp <= w_pp;
                r_sh <= {1'b0, r_i} + {1'b0, r_j};
                if (r_j == r_lb) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
            if (r_ppv) begin
                r_acc <= r_acc + w_pp_shift;
            end
        end
    end

endmodule

[src/bspt_window.sv]
module bspt_window #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 24
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write the new price, read the oldest one
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[src/bspt_checker.sv]
module bspt_checker
    import bspt_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic                     o_window_full,
    input logic [1:0]               o_action,
    input logic signed [POS_W-1:0]  o_position,
    input logic signed [CASH_W-1:0] o_cashflow,
    input logic signed [CASH_W-1:0] o_marked_pnl
);

    logic                    w_in_acc;
    logic                    w_out_acc;
    logic [1:0]              r_pend;
    logic signed [POS_W-1:0] r_prev_pos;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // Track items taken but not yet delivered, and the last delivered position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= '0;
            r_prev_pos <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, w_in_acc} - {1'b0, w_out_acc};
            if (w_out_acc) begin
                r_prev_pos <= o_position;
            end
        end
    end

    // A stalled item holds its fields
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_action)
            && $stable(o_window_full) && $stable(o_position)
            && $stable(o_cashflow) && $stable(o_marked_pnl))
        else $error("output item changed while stalled");

    // Every result belongs to an item taken earlier
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != 2'd0)
        else $error("result without a pending item");

    // At most one item in work plus one waiting result
    a_pend_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("too many pending items");

    // The block works on one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("item taken while busy");

    // Position moves by the reported trade only
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |->
            (o_action == ACT_BUY  && o_position == r_prev_pos + POS_W'(1))
         || (o_action == ACT_SELL && o_position == r_prev_pos - POS_W'(1))
         || (o_action == ACT_HOLD && o_position == r_prev_pos))
        else $error("position step does not match action");

endmodule

bind bollinger_signal_position_tracker bspt_checker u_bspt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_window_full (o_window_full),
    .o_action      (o_action),
    .o_position    (o_position),
    .o_cashflow    (o_cashflow),
    .o_marked_pnl  (o_marked_pnl)
);
